// File: src/json_string_literal_checker_assert.svh
// ----------------------------------------------------------------------------
// json string literal checker assertion macros
// shared property forms for the checker rtl
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_LITERAL_CHECKER_ASSERT_SVH
`define JSON_STRING_LITERAL_CHECKER_ASSERT_SVH

// same-cycle implication, off during reset
`define JSLC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jslc assertion failed");

// next-cycle implication, off during reset
`define JSLC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jslc assertion failed");

`endif

// File: src/jslc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jslc_pkg
// types, codes and helper functions for the json string literal checker
// ----------------------------------------------------------------------------
package jslc_pkg;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_CTRL       = 3'd1,
    ERR_UNTERM_ESC = 3'd2,
    ERR_SHORT_U    = 3'd3,
    ERR_BAD_HEX    = 3'd4,
    ERR_HIGH_SURR  = 3'd5,
    ERR_LONE_LOW   = 3'd6,
    ERR_BAD_ESC    = 3'd7
  } jslc_err_t;

  typedef enum logic [2:0] {
    PH_TEXT     = 3'd0,
    PH_ESC      = 3'd1,
    PH_HEX      = 3'd2,
    PH_PAIR_BS  = 3'd3,
    PH_PAIR_U   = 3'd4,
    PH_LOW_HEX  = 3'd5
  } jslc_phase_t;

  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,
    CLS_D    = 2'd1,
    CLS_HIGH = 2'd2,
    CLS_LOW  = 2'd3
  } jslc_class_t;

  typedef struct packed {
    logic        at_first;
    logic        opened;
    jslc_phase_t phase;
    logic [1:0]  hex_pos;
    jslc_class_t sclass;
    logic        pending;
    jslc_err_t   err;
    logic [7:0]  err_byte;
  } jslc_state_t;

  typedef struct packed {
    logic       is_string;
    jslc_err_t  code;
    logic [7:0] err_byte;
  } jslc_result_t;

  localparam jslc_state_t STATE_RESET = '{
    at_first: 1'b1, opened: 1'b0, phase: PH_TEXT, hex_pos: 2'd0,
    sclass: CLS_NONE, pending: 1'b0, err: ERR_NONE, err_byte: 8'h00
  };

  localparam logic [7:0] CTRL_LIMIT = 8'h20;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_B       = 8'h62;
  localparam logic [7:0] CH_F       = 8'h66;
  localparam logic [7:0] CH_N       = 8'h6E;
  localparam logic [7:0] CH_R       = 8'h72;
  localparam logic [7:0] CH_T       = 8'h74;
  localparam logic [7:0] CH_U       = 8'h75;

  // surrogate nibbles: 0xd800..0xdbff high, 0xdc00..0xdfff low
  localparam logic [3:0] NIB_D      = 4'hD;
  localparam logic [3:0] NIB_HIGH   = 4'h8;
  localparam logic [3:0] NIB_LOW    = 4'hC;

  // bit 4 set when the byte is not a hex digit, else bits 3:0 hold its value
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      return {1'b0, d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      return {1'b0, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      return {1'b0, d[3:0]};
    end
    return 5'h10;
  endfunction

  // track whether the code unit falls in the surrogate range
  function automatic jslc_class_t next_class(input logic [1:0] pos,
                                             input jslc_class_t cls,
                                             input logic [3:0] v);
    if (pos == 2'd0) begin
      return (v == NIB_D) ? CLS_D : CLS_NONE;
    end else if (pos == 2'd1) begin
      if (cls != CLS_D) return CLS_NONE;
      if (v >= NIB_LOW) return CLS_LOW;
      if (v >= NIB_HIGH) return CLS_HIGH;
      return CLS_NONE;
    end
    return cls;
  endfunction

endpackage

// File: src/json_string_literal_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_literal_checker
// validates the escapes and control bytes of one quoted json string literal
// ----------------------------------------------------------------------------
// usage:
//   bytes of a literal, quotes included, arrive on the char channel
//   (char_byte, is_last) with char_valid / char_stall; is_last marks the
//   closing byte. one transfer per cycle is sustained while char_stall is
//   low, one byte per cycle. each byte lands in an input register and is
//   scanned from there by a short state update; only the first error of
//   the literal is kept. on the closing byte one result (is_string,
//   error_code, error_byte) is loaded into the output register once that
//   byte has left the input register, which raises result_valid; the
//   next literal may follow with no gap.
//   a stalled result holds; interior bytes keep flowing, and only a closing
//   byte waits in the input register while the result register is full and
//   stalled, which then pushes char_stall back to the sender.
//   rst (synchronous) empties both registers and returns the scan state to
//   the start of a literal.
// ----------------------------------------------------------------------------
module json_string_literal_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  logic [7:0] char_byte,
  input  logic       is_last,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       is_string,
  output logic [2:0] error_code,
  output logic [7:0] error_byte
);
  import jslc_pkg::*;

  `include "json_string_literal_checker_assert.svh"

  // input register
  logic         char_q_valid;
  logic [7:0]   char_q_byte;
  logic         char_q_last;

  // scan state and its next value
  jslc_state_t  st;
  jslc_state_t  st_next;
  jslc_result_t res;

  logic         accept;
  logic         proc;

  // a held byte moves on unless it is a closing byte facing a full, stalled
  // result register
  assign proc       = char_q_valid && (!char_q_last || !result_valid || !result_stall);
  assign char_stall = char_q_valid && !proc;
  assign accept     = char_valid && !char_stall;

  jslc_scan u_scan (
    .st        (st),
    .char_byte (char_q_byte),
    .is_last   (char_q_last),
    .st_next   (st_next),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      char_q_valid <= 1'b0;
    end else if (accept) begin
      char_q_valid <= 1'b1;
    end else if (proc) begin
      char_q_valid <= 1'b0;
    end
  end

  // payload of the input register
  always_ff @(posedge clk) begin
    if (accept) begin
      char_q_byte <= char_byte;
      char_q_last <= is_last;
    end
  end

  // scan state advances once per processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (proc) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (proc && char_q_last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && char_q_last) begin
      is_string  <= res.is_string;
      error_code <= res.code;
      error_byte <= res.err_byte;
    end
  end

  // checks
  `JSLC_ASSERT_IMP(a_no_err_unless_string, clk, rst,
    result_valid && !is_string, error_code == ERR_NONE && error_byte == 8'h00)
  `JSLC_ASSERT_IMP(a_byte_only_for_byte_errors, clk, rst,
    result_valid && error_byte != 8'h00, error_code == ERR_CTRL || error_code == ERR_BAD_ESC)
  `JSLC_ASSERT_NXT(a_state_cleared_after_close, clk, rst,
    proc && char_q_last, st.at_first && st.err == ERR_NONE && st.phase == PH_TEXT)
  `JSLC_ASSERT_IMP(a_stall_only_on_full_output, clk, rst,
    char_stall, char_q_last && result_valid && result_stall)
  `JSLC_ASSERT_NXT(a_first_error_sticks, clk, rst,
    proc && !char_q_last && st.err != ERR_NONE, st.err == $past(st.err))

endmodule

// File: src/jslc_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jslc_scan
// next-state and result logic for one byte of a string literal
// ----------------------------------------------------------------------------
module jslc_scan (
  input  jslc_pkg::jslc_state_t  st,
  input  logic [7:0]             char_byte,
  input  logic                   is_last,
  output jslc_pkg::jslc_state_t  st_next,
  output jslc_pkg::jslc_result_t res
);
  import jslc_pkg::*;

  logic [4:0]  hv;
  logic        hex_ok;
  jslc_class_t cls_upd;
  jslc_class_t cls_eff;
  logic        is_str;
  logic        pend;

  assign hv      = hex_decode(char_byte);
  assign hex_ok  = !hv[4];
  assign cls_upd = next_class(st.hex_pos, st.sclass, hv[3:0]);
  assign cls_eff = hex_ok ? cls_upd : st.sclass;
  assign pend    = st.pending | !hex_ok;
  assign is_str  = !st.at_first && st.opened && (char_byte == CH_QUOTE);

  always_comb begin
    st_next = st;
    res     = '0;
    if (!is_last) begin
      if (st.at_first) begin
        st_next.at_first = 1'b0;
        st_next.opened   = (char_byte == CH_QUOTE);
      end else if (st.err == ERR_NONE) begin
        unique case (st.phase)
          PH_TEXT: begin
            if (char_byte < CTRL_LIMIT) begin
              st_next.err      = ERR_CTRL;
              st_next.err_byte = char_byte;
            end else if (char_byte == CH_BSLASH) begin
              st_next.phase = PH_ESC;
            end
          end
          PH_ESC: begin
            unique case (char_byte) inside
              CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T: begin
                st_next.phase = PH_TEXT;
              end
              CH_U: begin
                st_next.phase   = PH_HEX;
                st_next.hex_pos = 2'd0;
                st_next.sclass  = CLS_NONE;
                st_next.pending = 1'b0;
              end
              default: begin
                st_next.err      = ERR_BAD_ESC;
                st_next.err_byte = char_byte;
              end
            endcase
          end
          PH_HEX: begin
            st_next.pending = pend;
            st_next.sclass  = cls_eff;
            st_next.hex_pos = st.hex_pos + 2'd1;
            if (st.hex_pos == 2'd3) begin
              if (pend) begin
                st_next.err = ERR_BAD_HEX;
              end else if (cls_eff == CLS_HIGH) begin
                st_next.phase = PH_PAIR_BS;
              end else if (cls_eff == CLS_LOW) begin
                st_next.err = ERR_LONE_LOW;
              end else begin
                st_next.phase = PH_TEXT;
              end
            end
          end
          PH_PAIR_BS: begin
            if (char_byte == CH_BSLASH) st_next.phase = PH_PAIR_U;
            else st_next.err = ERR_HIGH_SURR;
          end
          PH_PAIR_U: begin
            if (char_byte == CH_U) begin
              st_next.phase   = PH_LOW_HEX;
              st_next.hex_pos = 2'd0;
              st_next.sclass  = CLS_NONE;
            end else begin
              st_next.err = ERR_HIGH_SURR;
            end
          end
          PH_LOW_HEX: begin
            if (!hex_ok) begin
              st_next.err = ERR_HIGH_SURR;
            end else begin
              st_next.sclass  = cls_upd;
              st_next.hex_pos = st.hex_pos + 2'd1;
              if (st.hex_pos == 2'd3) begin
                if (cls_upd == CLS_LOW) st_next.phase = PH_TEXT;
                else st_next.err = ERR_HIGH_SURR;
              end
            end
          end
          default: begin
            st_next = st;
          end
        endcase
      end
    end else begin
      res.code     = st.err;
      res.err_byte = st.err_byte;
      if (st.err == ERR_NONE) begin
        unique case (st.phase) inside
          PH_ESC:                            res.code = ERR_UNTERM_ESC;
          PH_HEX:                            res.code = ERR_SHORT_U;
          PH_PAIR_BS, PH_PAIR_U, PH_LOW_HEX: res.code = ERR_HIGH_SURR;
          default:                           res.code = ERR_NONE;
        endcase
      end
      if (!is_str) res = '0;
      res.is_string = is_str;
      st_next       = STATE_RESET;
    end
  end

endmodule

// File: dv/tb_json_string_literal_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_json_string_literal_checker
// self-checking bench for the json string literal checker: a short table of
// hand-picked literals with typed-in verdicts, then about two thousand bytes
// of random literals, mostly well formed with random escapes and surrogates,
// checked against a bit-accurate scan model kept inside the bench
// ----------------------------------------------------------------------------
module tb_json_string_literal_checker;
  import jslc_pkg::*;

  // clock and synchronous reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // char channel, driven on the falling edge
  logic       char_valid = 1'b0;
  logic       char_stall;
  logic [7:0] char_byte  = 8'h00;
  logic       is_last    = 1'b0;

  // result channel
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic       is_string;
  logic [2:0] error_code;
  logic [7:0] error_byte;

  json_string_literal_checker u_top (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_byte    (char_byte),
    .is_last      (is_last),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .is_string    (is_string),
    .error_code   (error_code),
    .error_byte   (error_byte)
  );

  // --------------------------------------------------------------------------
  // directed literals: one row per byte; closing rows carry the verdict,
  // typed in since each one is plain from the framing and the first error
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       typed;
    logic       want_str;
    jslc_err_t  want_code;
    logic [7:0] want_byte;
  } stim_row_t;

  localparam int DIR_ROWS = 30;

  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    // lone quote: too short to be a string
    '{8'h22, 1'b1, 1'b1, 1'b0, ERR_NONE,       8'h00},
    // a" : not opened by a quote
    '{8'h61, 1'b0, 1'b0, 1'b0, ERR_NONE,       8'h00},
    '{8'h22, 1'b1, 1'b1, 1'b0, ERR_NONE,       8'h00},
    // """ : bare interior quote is plain text
    '{8'h22, 1'b0, 1'b0, 1'b0, ERR_NONE,       8'h00},
    '{8'h22, 1'b0, 1'b0, 1'b0, ERR_NONE,       8'h00},
    '{8'h22, 1'b1, 1'b1, 1'b1, ERR_NONE,       8'h00},
    // top control byte
    '{8'h22, 1'b0, 1'b0, 1'b0, ERR_NONE,       8'h00},
    '{8'h1F, 1'b0, 1'b0, 1'b0, ERR_NONE,       8'h00},
    '{8'h22, 1'b1, 1'b1, 1'b1, ERR_CTRL,       8'h1F},
    // "\" : escape cut off by the closing quote
    '{8'h22, 1'b0, 1'b0, 1'b0, ERR_NONE,       8'h00},
    '{8'h5C, 1'b0, 1'b0, 1'b0, ERR_NONE,       8'h00},
    '{8'h22, 1'b1, 1'b1, 1'b1, ERR_UNTERM_ESC, 8'h00},
    // backslash then 0xff: unknown escape letter
    '{8'h22, 1'b0, 1'b0, 1'b0, ERR_NONE,       8'h00},
    '{8'h5C, 1'b0, 1'b0, 1'b0, ERR_NONE,       8'h00},
    '{8'hFF, 1'b0, 1'b0, 1'b0, ERR_NONE,       8'h00},
    '{8'h22, 1'b1, 1'b1, 1'b1, ERR_BAD_ESC,    8'hFF},
    // \u then 0x00: not a control error, non-hex then early end is short
    '{8'h22, 1'b0, 1'b0, 1'b0, ERR_NONE,       8'h00},
    '{8'h5C, 1'b0, 1'b0, 1'b0, ERR_NONE,       8'h00},
    '{8'h75, 1'b0, 1'b0, 1'b0, ERR_NONE,       8'h00},
    '{8'h00, 1'b0, 1'b0, 1'b0, ERR_NONE,       8'h00},
    '{8'h22, 1'b1, 1'b1, 1'b1, ERR_SHORT_U,    8'h00},
    // \uD800 then a control byte: pair failure wins over control
    '{8'h22, 1'b0, 1'b0, 1'b0, ERR_NONE,       8'h00},
    '{8'h5C, 1'b0, 1'b0, 1'b0, ERR_NONE,       8'h00},
    '{8'h75, 1'b0, 1'b0, 1'b0, ERR_NONE,       8'h00},
    '{8'h44, 1'b0, 1'b0, 1'b0, ERR_NONE,       8'h00},
    '{8'h38, 1'b0, 1'b0, 1'b0, ERR_NONE,       8'h00},
    '{8'h30, 1'b0, 1'b0, 1'b0, ERR_NONE,       8'h00},
    '{8'h30, 1'b0, 1'b0, 1'b0, ERR_NONE,       8'h00},
    '{8'h00, 1'b0, 1'b0, 1'b0, ERR_NONE,       8'h00},
    '{8'h22, 1'b1, 1'b1, 1'b1, ERR_HIGH_SURR,  8'h00}
  };

  // --------------------------------------------------------------------------
  // scan model state for the literal in flight
  // --------------------------------------------------------------------------
  logic        lit_at_open;
  logic        lit_quoted;
  jslc_phase_t lit_phase;
  logic [2:0]  lit_hex_idx;
  jslc_class_t lit_cls;
  logic        lit_bad_digit;
  jslc_err_t   lit_err;
  logic [7:0]  lit_err_byte;

  // verdicts waiting for the result channel, oldest first
  jslc_result_t literal_verdicts [$];

  // random literal under construction
  logic [7:0] lit_bytes [$];

  // bookkeeping
  int         fails          = 0;
  int         literals_sent  = 0;
  int         bytes_sent     = 0;
  int         verdicts_seen  = 0;
  logic [7:0] codes_seen     = 8'h00;
  logic       steady         = 1'b0;
  jslc_result_t got_want;

  task automatic clear_literal();
    lit_at_open   = 1'b1;
    lit_quoted    = 1'b0;
    lit_phase     = PH_TEXT;
    lit_hex_idx   = 3'd0;
    lit_cls       = CLS_NONE;
    lit_bad_digit = 1'b0;
    lit_err       = ERR_NONE;
    lit_err_byte  = 8'h00;
  endtask

  // bit 4 flags a non-hex byte, bits 3:0 carry the digit value
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [7:0] lc;
    lc = c | 8'h20;
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
    if (lc >= 8'h61 && lc <= 8'h66) return {1'b0, c[3:0] + 4'd9};
    return 5'h10;
  endfunction

  // only the first two digits decide whether the unit is a surrogate
  function automatic jslc_class_t unit_class(input logic [2:0] idx, input jslc_class_t cls,
                                             input logic [3:0] nib);
    jslc_class_t r;
    r = cls;
    if (idx == 3'd0) begin
      r = (nib == NIB_D) ? CLS_D : CLS_NONE;
    end else if (idx == 3'd1) begin
      if (cls != CLS_D) r = CLS_NONE;
      else if (nib >= NIB_LOW) r = CLS_LOW;
      else if (nib >= NIB_HIGH) r = CLS_HIGH;
      else r = CLS_NONE;
    end
    return r;
  endfunction

  task automatic note_error(input jslc_err_t code, input logic [7:0] b);
    lit_err      = code;
    lit_err_byte = b;
  endtask

  // one interior byte, only while no error has been seen
  task automatic scan_interior_byte(input logic [7:0] c);
    logic [4:0] d;
    d = digit_of(c);
    case (lit_phase)
      PH_TEXT: begin
        if (c < CTRL_LIMIT) note_error(ERR_CTRL, c);
        else if (c == CH_BSLASH) lit_phase = PH_ESC;
      end
      PH_ESC: begin
        case (c) inside
          CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T: lit_phase = PH_TEXT;
          CH_U: begin
            lit_phase     = PH_HEX;
            lit_hex_idx   = 3'd0;
            lit_cls       = CLS_NONE;
            lit_bad_digit = 1'b0;
          end
          default: note_error(ERR_BAD_ESC, c);
        endcase
      end
      PH_HEX: begin
        if (d[4]) lit_bad_digit = 1'b1;
        else lit_cls = unit_class(lit_hex_idx, lit_cls, d[3:0]);
        lit_hex_idx = lit_hex_idx + 3'd1;
        if (lit_hex_idx == 3'd4) begin
          lit_hex_idx = 3'd0;
          if (lit_bad_digit) note_error(ERR_BAD_HEX, 8'h00);
          else if (lit_cls == CLS_HIGH) lit_phase = PH_PAIR_BS;
          else if (lit_cls == CLS_LOW) note_error(ERR_LONE_LOW, 8'h00);
          else lit_phase = PH_TEXT;
        end
      end
      PH_PAIR_BS: begin
        if (c == CH_BSLASH) lit_phase = PH_PAIR_U;
        else note_error(ERR_HIGH_SURR, 8'h00);
      end
      PH_PAIR_U: begin
        if (c == CH_U) begin
          lit_phase   = PH_LOW_HEX;
          lit_hex_idx = 3'd0;
          lit_cls     = CLS_NONE;
        end else begin
          note_error(ERR_HIGH_SURR, 8'h00);
        end
      end
      default: begin
        // hex digits of the low half of a pair
        if (d[4]) begin
          note_error(ERR_HIGH_SURR, 8'h00);
        end else begin
          lit_cls     = unit_class(lit_hex_idx, lit_cls, d[3:0]);
          lit_hex_idx = lit_hex_idx + 3'd1;
          if (lit_hex_idx == 3'd4) begin
            lit_hex_idx = 3'd0;
            if (lit_cls == CLS_LOW) lit_phase = PH_TEXT;
            else note_error(ERR_HIGH_SURR, 8'h00);
          end
        end
      end
    endcase
  endtask

  // advance the scan by one accepted byte; the closing byte yields a verdict
  task automatic json_scan_step(input logic [7:0] c, input logic last,
                                output logic got, output jslc_result_t verdict);
    logic quoted;
    got     = 1'b0;
    verdict = '0;
    if (!last) begin
      if (lit_at_open) begin
        lit_at_open = 1'b0;
        lit_quoted  = (c == CH_QUOTE);
      end else if (lit_err == ERR_NONE) begin
        scan_interior_byte(c);
      end
    end else begin
      quoted = !lit_at_open && lit_quoted && (c == CH_QUOTE);
      // an escape still open at the closing quote
      if (quoted && lit_err == ERR_NONE) begin
        case (lit_phase) inside
          PH_ESC:                            note_error(ERR_UNTERM_ESC, 8'h00);
          PH_HEX:                            note_error(ERR_SHORT_U, 8'h00);
          PH_PAIR_BS, PH_PAIR_U, PH_LOW_HEX: note_error(ERR_HIGH_SURR, 8'h00);
          default: ;
        endcase
      end
      got               = 1'b1;
      verdict.is_string = quoted;
      verdict.code      = quoted ? lit_err : ERR_NONE;
      verdict.err_byte  = quoted ? lit_err_byte : 8'h00;
      clear_literal();
    end
  endtask

  // --------------------------------------------------------------------------
  // char side: called at a falling edge, returns at the falling edge after
  // the transfer; valid only drops outside the steady stretch, for each random idle cycle
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] ch, input logic last, input logic typed,
                           input jslc_result_t want);
    logic         got;
    jslc_result_t verdict;
    while (!steady && $urandom_range(99) < 17) begin
      char_valid <= 1'b0;
      @(negedge clk);
    end
    char_valid <= 1'b1;
    char_byte  <= ch;
    is_last    <= last;
    @(posedge clk);
    while (char_stall !== 1'b0) @(posedge clk);
    // transfer taken at this edge
    bytes_sent++;
    json_scan_step(ch, last, got, verdict);
    if (got) literal_verdicts.push_back(typed ? want : verdict);
    @(negedge clk);
  endtask

  // four hex digits of one code unit, case picked at random
  task automatic push_unit(input logic [15:0] u);
    int         k;
    logic [3:0] n;
    for (k = 3; k >= 0; k--) begin
      n = u[k*4 +: 4];
      if (n < 4'd10) lit_bytes.push_back(8'h30 + {4'h0, n});
      else lit_bytes.push_back(($urandom_range(1) ? 8'h41 : 8'h61) + {4'h0, n} - 8'd10);
    end
  endtask

  task automatic push_random_unit();
    logic [15:0] u;
    case ($urandom_range(3))
      0:       u = 16'($urandom_range(16'hFFFF));
      1:       u = 16'hD800 + 16'($urandom_range(10'h3FF));  // high half
      2:       u = 16'hDC00 + 16'($urandom_range(10'h3FF));  // low half
      default: u = 16'hD000 + 16'($urandom_range(12'hFFF));  // anywhere in 0xd000..0xdfff
    endcase
    lit_bytes.push_back(CH_BSLASH);
    lit_bytes.push_back(CH_U);
    push_unit(u);
  endtask

  // mostly well-formed literal with random content, some noise and breakage
  task automatic make_literal();
    int         nseg;
    int         seg_start;
    int         pos;
    int         cut;
    int         kind;
    logic [7:0] b;
    lit_bytes.delete();
    if ($urandom_range(99) < 8) begin
      // raw noise, framing included
      repeat ($urandom_range(6, 1)) lit_bytes.push_back(8'($urandom_range(255)));
    end else begin
      lit_bytes.push_back(($urandom_range(99) < 96) ? CH_QUOTE : 8'($urandom_range(255)));
      nseg = $urandom_range(6);
      repeat (nseg) begin
        seg_start = lit_bytes.size();
        kind      = $urandom_range(99);
        if (kind < 40) begin
          // non-control text byte, backslash swapped for a bare quote
          b = 8'($urandom_range(8'hFF, 8'h20));
          lit_bytes.push_back((b == CH_BSLASH) ? CH_QUOTE : b);
        end else if (kind < 44) begin
          lit_bytes.push_back(8'($urandom_range(8'h1F)));
        end else if (kind < 60) begin
          lit_bytes.push_back(CH_BSLASH);
          case ($urandom_range(7))
            0:       lit_bytes.push_back(CH_QUOTE);
            1:       lit_bytes.push_back(CH_BSLASH);
            2:       lit_bytes.push_back(CH_SLASH);
            3:       lit_bytes.push_back(CH_B);
            4:       lit_bytes.push_back(CH_F);
            5:       lit_bytes.push_back(CH_N);
            6:       lit_bytes.push_back(CH_R);
            default: lit_bytes.push_back(CH_T);
          endcase
        end else if (kind < 63) begin
          lit_bytes.push_back(CH_BSLASH);
          lit_bytes.push_back(8'($urandom_range(255)));
        end else if (kind < 80) begin
          push_random_unit();
        end else if (kind < 95) begin
          // proper surrogate pair
          lit_bytes.push_back(CH_BSLASH);
          lit_bytes.push_back(CH_U);
          push_unit(16'hD800 + 16'($urandom_range(10'h3FF)));
          lit_bytes.push_back(CH_BSLASH);
          lit_bytes.push_back(CH_U);
          push_unit(16'hDC00 + 16'($urandom_range(10'h3FF)));
        end else begin
          // high half followed by a broken escape
          lit_bytes.push_back(CH_BSLASH);
          lit_bytes.push_back(CH_U);
          push_unit(16'hD800 + 16'($urandom_range(10'h3FF)));
          lit_bytes.push_back(CH_BSLASH);
          lit_bytes.push_back(8'($urandom_range(255)));
        end
        // occasional corrupted byte inside the segment
        if ($urandom_range(99) < 4) begin
          pos            = $urandom_range(lit_bytes.size() - 1, seg_start);
          lit_bytes[pos] = 8'($urandom_range(255));
        end
      end
      // cut the body short now and then, leaving escapes open
      if (lit_bytes.size() > 1 && $urandom_range(99) < 6) begin
        cut = $urandom_range(lit_bytes.size() - 1, 1);
        while (lit_bytes.size() > cut) lit_bytes.delete(lit_bytes.size() - 1);
      end
      lit_bytes.push_back(($urandom_range(99) < 96) ? CH_QUOTE : 8'($urandom_range(255)));
    end
  endtask

  // --------------------------------------------------------------------------
  // result side: random stall, changed on the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    result_stall <= !steady && ($urandom_range(99) < 17);
  end

  // compare each result transfer with the oldest waiting verdict
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      codes_seen[error_code] <= 1'b1;
      if (literal_verdicts.size() == 0) begin
        $display("%0t ns: result with no literal pending: is_string %0d code %0d byte %h",
                 $time, is_string, error_code, error_byte);
        fails++;
      end else begin
        got_want = literal_verdicts.pop_front();
        verdicts_seen++;
        if (is_string !== got_want.is_string) begin
          $display("%0t ns: is_string mismatch: expected %0d, got %0d",
                   $time, got_want.is_string, is_string);
          fails++;
        end
        if (error_code !== got_want.code) begin
          $display("%0t ns: error_code mismatch: expected %0d, got %0d",
                   $time, got_want.code, error_code);
          fails++;
        end
        if (error_byte !== got_want.err_byte) begin
          $display("%0t ns: error_byte mismatch: expected %h, got %h",
                   $time, got_want.err_byte, error_byte);
          fails++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int           i;
    int           k;
    jslc_result_t row_want;
    clear_literal();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (i = 0; i < DIR_ROWS; i++) begin
      row_want = '{DIRECTED[i].want_str, DIRECTED[i].want_code, DIRECTED[i].want_byte};
      send_byte(DIRECTED[i].ch, DIRECTED[i].last, DIRECTED[i].typed, row_want);
      if (DIRECTED[i].last) literals_sent++;
    end

    // random literals, with a stretch of back-to-back traffic on both sides
    while (bytes_sent < 2000) begin
      steady <= (bytes_sent >= 800 && bytes_sent < 1200);
      make_literal();
      for (k = 0; k < lit_bytes.size(); k++)
        send_byte(lit_bytes[k], k == lit_bytes.size() - 1, 1'b0, '0);
      literals_sent++;
    end
    char_valid <= 1'b0;

    // drain the verdicts, then idle to catch anything stray
    while (literal_verdicts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d literals in %0d byte transfers, %0d verdicts compared",
             literals_sent, bytes_sent, verdicts_seen);
    $display("error codes returned, one bit per code: %b", codes_seen);
    if (fails == 0) begin
      $display("tb_json_string_literal_checker passed");
    end else begin
      $display("tb_json_string_literal_checker failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("timeout with %0d literals still pending", literal_verdicts.size());
    $display("tb_json_string_literal_checker failed");
    $finish;
  end

endmodule
